// ----- sv/fsp8_pkg.sv -----
package fsp8_pkg;

   localparam int COUNTER_BITS = 32;
   localparam int NUM_COUNTERS = 10;

   // item operations
   typedef enum logic [2:0] {
      OP_WR_IMEM = 3'd0,
      OP_WR_DMEM = 3'd1,
      OP_WR_REG  = 3'd2,
      OP_RD_DMEM = 3'd3,
      OP_RD_REG  = 3'd4,
      OP_RD_CNT  = 3'd5,
      OP_START   = 3'd6,
      OP_STEP    = 3'd7
   } op_type;

   // instruction opcodes
   localparam logic [3:0] OPC_ADD  = 4'd0;
   localparam logic [3:0] OPC_SUB  = 4'd1;
   localparam logic [3:0] OPC_MUL  = 4'd2;
   localparam logic [3:0] OPC_INC  = 4'd3;
   localparam logic [3:0] OPC_AND  = 4'd4;
   localparam logic [3:0] OPC_OR   = 4'd5;
   localparam logic [3:0] OPC_XOR  = 4'd6;
   localparam logic [3:0] OPC_NOT  = 4'd7;
   localparam logic [3:0] OPC_SLLI = 4'd8;
   localparam logic [3:0] OPC_SRLI = 4'd9;
   localparam logic [3:0] OPC_LI   = 4'd10;
   localparam logic [3:0] OPC_LD   = 4'd11;
   localparam logic [3:0] OPC_ST   = 4'd12;
   localparam logic [3:0] OPC_JMP  = 4'd13;
   localparam logic [3:0] OPC_BEQZ = 4'd14;
   localparam logic [3:0] OPC_HLT  = 4'd15;

   // statistics counter indexes
   localparam logic [3:0] CNT_ARITH  = 4'd0;
   localparam logic [3:0] CNT_LOGIC  = 4'd1;
   localparam logic [3:0] CNT_SHIFT  = 4'd2;
   localparam logic [3:0] CNT_MEM    = 4'd3;
   localparam logic [3:0] CNT_LI     = 4'd4;
   localparam logic [3:0] CNT_CTRL   = 4'd5;
   localparam logic [3:0] CNT_HALT   = 4'd6;
   localparam logic [3:0] CNT_CYCLES = 4'd7;
   localparam logic [3:0] CNT_DSTALL = 4'd8;
   localparam logic [3:0] CNT_CSTALL = 4'd9;

   typedef struct packed {
      logic [3:0] opcode;
      logic [3:0] rd;
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] imm;
      logic       dependency;
      logic       jump;
   } dec_latch_type;

   typedef struct packed {
      logic [3:0] opcode;
      logic [3:0] rd;
      logic [7:0] alu_out;
   } ex_latch_type;

   typedef struct packed {
      logic [3:0] opcode;
      logic [3:0] rd;
      logic [7:0] lmd;
   } mem_latch_type;

   // operands handed to the alu
   typedef struct packed {
      logic [3:0] opcode;
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] pc;
   } alu_req_type;

endpackage

// ----- sv/fsp8_alu.sv -----
module fsp8_alu import fsp8_pkg::*; (
   input  alu_req_type alu_req,
   output logic [7:0]  alu_result
);

   logic [15:0] product;

   assign product = {8'd0, alu_req.a} * {8'd0, alu_req.b};

   // result wraps to 8 bits
   always_comb begin
      case (alu_req.opcode)
         OPC_ADD, OPC_LD, OPC_ST: alu_result = alu_req.a + alu_req.b;
         OPC_SUB:  alu_result = alu_req.a - alu_req.b;
         OPC_MUL:  alu_result = product[7:0];
         OPC_INC:  alu_result = alu_req.a + 8'd1;
         OPC_AND:  alu_result = alu_req.a & alu_req.b;
         OPC_OR:   alu_result = alu_req.a | alu_req.b;
         OPC_XOR:  alu_result = alu_req.a ^ alu_req.b;
         OPC_NOT:  alu_result = ~alu_req.a;
         OPC_SLLI: alu_result = (alu_req.b < 8'd8) ? (alu_req.a << alu_req.b[2:0]) : 8'd0;
         OPC_SRLI: alu_result = (alu_req.b < 8'd8) ? (alu_req.a >> alu_req.b[2:0]) : 8'd0;
         OPC_BEQZ: alu_result = (alu_req.a == 8'd0) ?
                                (alu_req.pc + {alu_req.b[6:0], 1'b0}) : alu_req.pc;
         default:  alu_result = 8'd0;
      endcase
   end

endmodule

// ----- sv/five_stage_pipelined_8bit_cpu_core.sv -----
// channel  direction  ports
// req      in         req_valid, req_ready, req_operation, req_address, req_data
// rsp      out        rsp_valid, rsp_ready, rsp_read_data, rsp_active, rsp_program_counter
//
// one transaction per cycle while ready; each step transaction runs one pipeline clock (wb,
// mem, ex, id, if) in a single pass of logic between the state and the result register
// the result is registered and appears in the cycle after acceptance
// req_ready stays high while the result register is empty or being taken
// reset clears pipeline state and counters; memories and registers hold until written
// fetch word and load byte are read ahead into registers, writes forwarded
module five_stage_pipelined_8bit_cpu_core import fsp8_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [7:0]  req_address,
   input  logic [7:0]  req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic        rsp_active,
   output logic [7:0]  rsp_program_counter
);

   logic [7:0]  imem [256];
   logic [7:0]  dmem [256];
   logic [7:0]  rf_ff [16];
   logic [7:0]  rf_in [16];
   logic [1:0]  busy_ff [16];
   logic [1:0]  busy_in [16];
   logic [COUNTER_BITS-1:0] cnt_ff [NUM_COUNTERS];
   logic [COUNTER_BITS-1:0] cnt_in [NUM_COUNTERS];
   logic [7:0]  pc_ff, pc_in, pc_mem;
   logic [15:0] fl_ff, fl_in;
   dec_latch_type dl_ff, dl_in;
   ex_latch_type  el_ff, el_in;
   mem_latch_type ml_ff, ml_in;
   logic [4:0]  free_ff, free_in, skip_ff, skip_in;
   logic        work_in;
   logic        dm_we;
   logic [7:0]  dm_addr, dm_wdata;
   logic        dm_wr_en;
   logic [7:0]  dm_wr_addr, dm_wr_data;
   logic [7:0]  nx_pc, nx_fetch_pc, nx_fetch_lo;
   ex_latch_type nx_el;
   logic        nx_mem_on;
   logic [7:0]  if_hi_ff, if_lo_ff, ld_data_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic        rsp_active_ff;
   logic [7:0]  rsp_pc_ff;
   logic        accept;
   op_type      op;
   alu_req_type alu_req;
   logic [7:0]  alu_result;

   assign op        = op_type'(req_operation);
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // pc as left by the memory stage
   always_comb begin
      pc_mem = pc_ff;
      if (!skip_ff[3] && free_ff[3]) begin
         if (el_ff.opcode == OPC_JMP) begin
            pc_mem = pc_ff + el_ff.alu_out;
         end else if (el_ff.opcode == OPC_BEQZ) begin
            pc_mem = el_ff.alu_out;
         end
      end
   end

   // alu operand selection for the execute stage
   always_comb begin
      alu_req.opcode = dl_ff.opcode;
      alu_req.a      = dl_ff.a;
      alu_req.pc     = pc_mem;
      if (dl_ff.opcode == OPC_INC || dl_ff.opcode == OPC_NOT) begin
         alu_req.b = 8'd0;
      end else if (dl_ff.opcode inside {OPC_SLLI, OPC_SRLI, OPC_LD, OPC_ST, OPC_BEQZ}) begin
         alu_req.b = dl_ff.imm;
      end else begin
         alu_req.b = dl_ff.b;
      end
   end

   fsp8_alu u_alu (
      .alu_req    (alu_req),
      .alu_result (alu_result)
   );

   // one pipeline clock: wb, mem, ex, id, if in that order
   always_comb begin
      logic [15:0] w;
      logic [3:0]  f_rd, f_rs, f_rt;
      logic        dep;
      skip_in = skip_ff;
      free_in = free_ff;
      rf_in   = rf_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      fl_in   = fl_ff;
      dl_in   = dl_ff;
      el_in   = el_ff;
      ml_in   = ml_ff;
      pc_in   = pc_ff;
      work_in = 1'b0;
      dm_we   = 1'b0;
      dm_addr = el_ff.alu_out;
      dm_wdata = 8'd0;
      dep     = 1'b0;
      w       = fl_ff;
      f_rd    = w[11:8];
      f_rs    = w[7:4];
      f_rt    = w[3:0];

      // write back
      if (!skip_in[4] && free_in[4]) begin
         work_in = 1'b1;
         if (!(ml_ff.opcode inside {OPC_HLT, OPC_ST, OPC_JMP, OPC_BEQZ})) begin
            rf_in[ml_ff.rd]   = ml_ff.lmd;
            busy_in[ml_ff.rd] = busy_in[ml_ff.rd] - 2'd1;
         end
      end

      // memory
      if (!(!skip_in[3] && free_in[3])) begin
         skip_in[4] = 1'b1;
      end else begin
         ml_in.opcode = el_ff.opcode;
         skip_in[4]   = 1'b0;
         work_in      = 1'b1;
         pc_in        = pc_mem;
         if (el_ff.opcode == OPC_LD) begin
            ml_in.lmd = ld_data_ff;
            ml_in.rd  = el_ff.rd;
         end else if (el_ff.opcode == OPC_ST) begin
            dm_we    = 1'b1;
            dm_wdata = rf_in[el_ff.rd];
         end else if (!(el_ff.opcode inside {OPC_HLT, OPC_JMP, OPC_BEQZ})) begin
            ml_in.rd  = el_ff.rd;
            ml_in.lmd = el_ff.alu_out;
         end
      end

      // execute
      if (!(!skip_in[2] && free_in[2])) begin
         skip_in[3] = 1'b1;
      end else begin
         work_in      = 1'b1;
         skip_in[3]   = 1'b0;
         el_in.opcode = dl_ff.opcode;
         case (dl_ff.opcode)
            OPC_ADD, OPC_SUB, OPC_MUL, OPC_INC: begin
               cnt_in[CNT_ARITH] = cnt_in[CNT_ARITH] + 1'b1;
               el_in.alu_out = alu_result;
               el_in.rd      = dl_ff.rd;
            end
            OPC_AND, OPC_OR, OPC_XOR, OPC_NOT: begin
               cnt_in[CNT_LOGIC] = cnt_in[CNT_LOGIC] + 1'b1;
               el_in.alu_out = alu_result;
               el_in.rd      = dl_ff.rd;
            end
            OPC_SLLI, OPC_SRLI: begin
               cnt_in[CNT_SHIFT] = cnt_in[CNT_SHIFT] + 1'b1;
               el_in.alu_out = alu_result;
               el_in.rd      = dl_ff.rd;
            end
            OPC_LD, OPC_ST: begin
               cnt_in[CNT_MEM] = cnt_in[CNT_MEM] + 1'b1;
               el_in.alu_out = alu_result;
               el_in.rd      = dl_ff.rd;
            end
            OPC_LI: begin
               cnt_in[CNT_LI] = cnt_in[CNT_LI] + 1'b1;
               el_in.alu_out = dl_ff.imm;
               el_in.rd      = dl_ff.rd;
            end
            OPC_JMP: begin
               cnt_in[CNT_CTRL] = cnt_in[CNT_CTRL] + 1'b1;
               el_in.alu_out = {dl_ff.imm[6:0], 1'b0};
               free_in[1:0]  = 2'b00;
            end
            OPC_BEQZ: begin
               cnt_in[CNT_CTRL] = cnt_in[CNT_CTRL] + 1'b1;
               el_in.alu_out = alu_result;
               free_in[1:0]  = 2'b00;
            end
            default: begin
               cnt_in[CNT_HALT] = cnt_in[CNT_HALT] + 1'b1;
            end
         endcase
      end

      // decode with scoreboard check
      if (!(!skip_in[1] && free_in[1])) begin
         skip_in[2] = 1'b1;
      end else begin
         work_in      = 1'b1;
         dl_in.opcode = w[15:12];
         dl_in.rd     = f_rd;
         dl_in.jump   = 1'b0;
         case (w[15:12])
            OPC_ADD, OPC_SUB, OPC_MUL, OPC_AND, OPC_OR, OPC_XOR: begin
               if (busy_in[f_rs] != 2'd0 || busy_in[f_rt] != 2'd0) begin
                  dep = 1'b1;
               end else begin
                  busy_in[f_rd] = busy_in[f_rd] + 2'd1;
                  dl_in.a = rf_in[f_rs];
                  dl_in.b = rf_in[f_rt];
               end
            end
            OPC_NOT: begin
               if (busy_in[f_rs] != 2'd0) begin
                  dep = 1'b1;
               end else begin
                  busy_in[f_rd] = busy_in[f_rd] + 2'd1;
                  dl_in.a = rf_in[f_rs];
                  dl_in.b = 8'd0;
               end
            end
            OPC_SLLI, OPC_SRLI, OPC_LD: begin
               if (busy_in[f_rs] != 2'd0) begin
                  dep = 1'b1;
               end else begin
                  busy_in[f_rd] = busy_in[f_rd] + 2'd1;
                  dl_in.a   = rf_in[f_rs];
                  dl_in.imm = w[7:0];
               end
            end
            OPC_ST: begin
               if (busy_in[f_rs] != 2'd0 || busy_in[f_rd] != 2'd0) begin
                  dep = 1'b1;
               end else begin
                  dl_in.a   = rf_in[f_rs];
                  dl_in.imm = w[7:0];
               end
            end
            OPC_INC: begin
               if (busy_in[f_rd] != 2'd0) begin
                  dep = 1'b1;
               end else begin
                  busy_in[f_rd] = busy_in[f_rd] + 2'd1;
                  dl_in.a = rf_in[f_rd];
                  dl_in.b = 8'd0;
               end
            end
            OPC_LI: begin
               busy_in[f_rd] = busy_in[f_rd] + 2'd1;
               dl_in.imm     = w[7:0];
            end
            OPC_JMP: begin
               dl_in.a    = 8'd0;
               dl_in.b    = 8'd0;
               dl_in.jump = 1'b1;
               dl_in.imm  = w[11:4];
            end
            OPC_BEQZ: begin
               if (busy_in[f_rd] != 2'd0) begin
                  dep = 1'b1;
               end else begin
                  dl_in.jump = 1'b1;
                  dl_in.a    = rf_in[f_rd];
                  dl_in.b    = 8'd0;
                  dl_in.imm  = w[7:0];
               end
            end
            default: begin
               skip_in[0] = 1'b1;
            end
         endcase
         dl_in.dependency = dep;
         if (dep) begin
            cnt_in[CNT_DSTALL] = cnt_in[CNT_DSTALL] + 1'b1;
            free_in[0] = 1'b0;
            skip_in[2] = 1'b1;
         end else if (dl_in.jump) begin
            cnt_in[CNT_CSTALL] = cnt_in[CNT_CSTALL] + 2'd2;
            free_in[0] = 1'b0;
            skip_in[1] = 1'b1;
            skip_in[2] = 1'b0;
         end else begin
            skip_in[2] = 1'b0;
         end
      end

      // fetch from the prefetched word at the pc left by the memory stage
      if (!(!skip_in[0] && free_in[0])) begin
         if (!dl_in.dependency) begin
            skip_in[1] = 1'b1;
         end
      end else begin
         work_in    = 1'b1;
         fl_in      = {if_hi_ff, if_lo_ff};
         pc_in      = pc_in + 8'd2;
         skip_in[1] = 1'b0;
      end

      free_in = 5'h1F;
      if (work_in) begin
         cnt_in[CNT_CYCLES] = cnt_in[CNT_CYCLES] + 1'b1;
      end
   end

   // state seen by the next step, for the memory prefetch addresses
   always_comb begin
      if (reset || (accept && op == OP_START)) begin
         nx_pc     = '0;
         nx_el     = '0;
         nx_mem_on = 1'b0;
      end else if (accept && op == OP_STEP) begin
         nx_pc     = pc_in;
         nx_el     = el_in;
         nx_mem_on = !skip_in[3] && free_in[3];
      end else begin
         nx_pc     = pc_ff;
         nx_el     = el_ff;
         nx_mem_on = !skip_ff[3] && free_ff[3];
      end
      nx_fetch_pc = nx_pc;
      if (nx_mem_on) begin
         if (nx_el.opcode == OPC_JMP) begin
            nx_fetch_pc = nx_pc + nx_el.alu_out;
         end else if (nx_el.opcode == OPC_BEQZ) begin
            nx_fetch_pc = nx_el.alu_out;
         end
      end
   end

   assign nx_fetch_lo = nx_fetch_pc + 8'd1;

   // data memory write source
   always_comb begin
      dm_wr_en   = 1'b0;
      dm_wr_addr = req_address;
      dm_wr_data = req_data;
      if (accept && op == OP_WR_DMEM) begin
         dm_wr_en = 1'b1;
      end else if (accept && op == OP_STEP && dm_we) begin
         dm_wr_en   = 1'b1;
         dm_wr_addr = dm_addr;
         dm_wr_data = dm_wdata;
      end
   end

   // instruction memory with registered fetch word
   always_ff @(posedge clock) begin
      if (accept && op == OP_WR_IMEM) begin
         imem[req_address] <= req_data;
      end
      if (accept && op == OP_WR_IMEM && req_address == nx_fetch_pc) begin
         if_hi_ff <= req_data;
      end else begin
         if_hi_ff <= imem[nx_fetch_pc];
      end
      if (accept && op == OP_WR_IMEM && req_address == nx_fetch_lo) begin
         if_lo_ff <= req_data;
      end else begin
         if_lo_ff <= imem[nx_fetch_lo];
      end
   end

   // data memory with registered load byte
   always_ff @(posedge clock) begin
      if (dm_wr_en) begin
         dmem[dm_wr_addr] <= dm_wr_data;
      end
      if (dm_wr_en && dm_wr_addr == nx_el.alu_out) begin
         ld_data_ff <= dm_wr_data;
      end else begin
         ld_data_ff <= dmem[nx_el.alu_out];
      end
   end

   // register file
   always_ff @(posedge clock) begin
      if (accept && op == OP_WR_REG) begin
         rf_ff[req_address[3:0]] <= req_data;
      end else if (accept && op == OP_STEP) begin
         rf_ff <= rf_in;
      end
   end

   // pipeline state
   always_ff @(posedge clock) begin
      if (reset || (accept && op == OP_START)) begin
         pc_ff   <= '0;
         fl_ff   <= '0;
         dl_ff   <= '0;
         el_ff   <= '0;
         ml_ff   <= '0;
         free_ff <= 5'b00001;
         skip_ff <= 5'b11100;
         for (int i = 0; i < 16; i++) begin
            busy_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_COUNTERS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (accept && op == OP_STEP) begin
         pc_ff   <= pc_in;
         fl_ff   <= fl_in;
         dl_ff   <= dl_in;
         el_ff   <= el_in;
         ml_ff   <= ml_in;
         free_ff <= free_in;
         skip_ff <= skip_in;
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff   <= '0;
         rsp_active_ff <= 1'b0;
         rsp_pc_ff     <= pc_ff;
         case (op)
            OP_RD_DMEM: rsp_data_ff <= {24'd0, dmem[req_address]};
            OP_RD_REG:  rsp_data_ff <= {24'd0, rf_ff[req_address[3:0]]};
            OP_RD_CNT: begin
               if (req_address < 8'(NUM_COUNTERS)) begin
                  rsp_data_ff <= 32'(cnt_ff[req_address[3:0]]);
               end
            end
            OP_START:   rsp_pc_ff <= '0;
            OP_STEP: begin
               rsp_active_ff <= work_in;
               rsp_pc_ff     <= pc_in;
            end
            default: rsp_data_ff <= '0;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = rsp_data_ff;
   assign rsp_active          = rsp_active_ff;
   assign rsp_program_counter = rsp_pc_ff;

`ifndef SYNTHESIS
   // pc only moves by even amounts from zero
   assert property (@(posedge clock) disable iff (reset) pc_ff[0] == 1'b0)
      else $error("odd program counter");

   // non-step transactions never report activity
   assert property (@(posedge clock) disable iff (reset)
      (accept && op != OP_STEP) |=> !rsp_active_ff)
      else $error("activity on non-step result");

   // a start returns the machine to its initial stage masks
   assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_START) |=> (free_ff == 5'b00001 && skip_ff == 5'b11100
                                      && pc_ff == 8'd0))
      else $error("start did not reset pipeline");

   // the result register is never overwritten before it is taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !accept)
      else $error("result overwritten");
`endif

endmodule

// ----- bench/five_stage_pipelined_8bit_cpu_core_tb.sv -----
`timescale 1ns / 100ps

module five_stage_pipelined_8bit_cpu_core_tb;
   import fsp8_pkg::*;

   typedef struct {
      op_type     op;
      logic [7:0] addr;
      logic [7:0] data;
   } cpu_item_type;

   typedef struct {
      logic [31:0] read_data;
      logic        active;
      logic [7:0]  pc;
   } cpu_result_type;

   localparam int CYCLE_LIMIT = 200000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_operation;
   logic [7:0]  req_address;
   logic [7:0]  req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_read_data;
   logic        rsp_active;
   logic [7:0]  rsp_program_counter;

   five_stage_pipelined_8bit_cpu_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_address(req_address),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_data(rsp_read_data),
      .rsp_active(rsp_active),
      .rsp_program_counter(rsp_program_counter)
   );

   // shadow machine state
   logic [7:0]    sh_imem [256];
   logic [7:0]    sh_dmem [256];
   logic [7:0]    sh_regs [16];
   logic [1:0]    sh_busy [16];
   logic [7:0]    sh_pc;
   logic [15:0]   sh_fetch;
   dec_latch_type sh_dec;
   ex_latch_type  sh_ex;
   mem_latch_type sh_mem;
   logic [4:0]    sh_free;
   logic [4:0]    sh_skip;
   logic [31:0]   sh_stats [10];
   int            sh_work;

   cpu_item_type   pending_items[$];
   cpu_result_type expected_results[$];
   cpu_item_type   cur_item;
   int          error_count;
   int          cycle_count;
   int          accepted_count;
   int          step_count;
   int          active_count;
   int          checked_count;
   bit          took_item;
   bit          stim_done;

   task automatic report_mismatch(input string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // machine restart: memories and registers kept
   function automatic void shadow_start();
      for (int i = 0; i < 16; i++) sh_busy[i] = '0;
      for (int i = 0; i < 10; i++) sh_stats[i] = '0;
      sh_dec = '0;
      sh_ex = '0;
      sh_mem = '0;
      sh_pc = '0;
      sh_fetch = '0;
      sh_free = 5'b00001;
      sh_skip = 5'b11100;
   endfunction

   function automatic void bump_stat(input logic [3:0] idx, input logic [31:0] amt);
      sh_stats[idx] = sh_stats[idx] + amt;
   endfunction

   function automatic bit stage_on(input int s);
      return !sh_skip[s] && sh_free[s];
   endfunction

   function automatic logic [7:0] alu_result(input logic [3:0] opc, input logic [7:0] a,
                                              input logic [7:0] b);
      case (opc)
         OPC_ADD, OPC_LD, OPC_ST: return a + b;
         OPC_SUB:  return a - b;
         OPC_MUL:  return a * b;
         OPC_INC:  return a + 8'd1;
         OPC_AND:  return a & b;
         OPC_OR:   return a | b;
         OPC_XOR:  return a ^ b;
         OPC_NOT:  return ~a;
         OPC_SLLI: return (b < 8) ? 8'(a << b) : 8'd0;
         OPC_SRLI: return (b < 8) ? (a >> b) : 8'd0;
         OPC_BEQZ: return (a == 0) ? 8'(sh_pc + 2 * b) : sh_pc;
         default:  return 8'd0;
      endcase
   endfunction

   // writeback
   function automatic void stage_writeback();
      logic [3:0] opc;
      logic [3:0] rd;
      opc = sh_mem.opcode;
      rd = sh_mem.rd;
      if (!stage_on(4)) return;
      sh_work++;
      if (opc == OPC_HLT || opc == OPC_ST || opc == OPC_JMP || opc == OPC_BEQZ) return;
      sh_regs[rd] = sh_mem.lmd;
      sh_busy[rd] = sh_busy[rd] - 2'd1;
   endfunction

   // memory access, jump and branch resolution
   function automatic void stage_memory();
      logic [3:0] opc;
      if (!stage_on(3)) begin
         sh_skip[4] = 1'b1;
         return;
      end
      opc = sh_ex.opcode;
      sh_mem.opcode = opc;
      sh_skip[4] = 1'b0;
      sh_work++;
      if (opc == OPC_HLT) return;
      if (opc == OPC_JMP) begin
         sh_pc = sh_pc + sh_ex.alu_out;
      end else if (opc == OPC_BEQZ) begin
         sh_pc = sh_ex.alu_out;
      end else if (opc == OPC_LD) begin
         sh_mem.lmd = sh_dmem[sh_ex.alu_out];
         sh_mem.rd = sh_ex.rd;
      end else if (opc == OPC_ST) begin
         sh_dmem[sh_ex.alu_out] = sh_regs[sh_ex.rd];
      end else begin
         sh_mem.rd = sh_ex.rd;
         sh_mem.lmd = sh_ex.alu_out;
      end
   endfunction

   // execute
   function automatic void stage_execute();
      logic [3:0] opc;
      opc = sh_dec.opcode;
      if (!stage_on(2)) begin
         sh_skip[3] = 1'b1;
         return;
      end
      sh_work++;
      sh_skip[3] = 1'b0;
      sh_ex.opcode = opc;
      case (opc)
         OPC_ADD, OPC_SUB, OPC_MUL, OPC_INC: begin
            bump_stat(CNT_ARITH, 1);
            sh_ex.alu_out = alu_result(opc, sh_dec.a, sh_dec.b);
            sh_ex.rd = sh_dec.rd;
         end
         OPC_AND, OPC_OR, OPC_XOR, OPC_NOT: begin
            bump_stat(CNT_LOGIC, 1);
            sh_ex.alu_out = alu_result(opc, sh_dec.a, sh_dec.b);
            sh_ex.rd = sh_dec.rd;
         end
         OPC_SLLI, OPC_SRLI: begin
            bump_stat(CNT_SHIFT, 1);
            sh_ex.alu_out = alu_result(opc, sh_dec.a, sh_dec.imm);
            sh_ex.rd = sh_dec.rd;
         end
         OPC_LD, OPC_ST: begin
            bump_stat(CNT_MEM, 1);
            sh_ex.alu_out = alu_result(opc, sh_dec.a, sh_dec.imm);
            sh_ex.rd = sh_dec.rd;
         end
         OPC_LI: begin
            bump_stat(CNT_LI, 1);
            sh_ex.alu_out = sh_dec.imm;
            sh_ex.rd = sh_dec.rd;
         end
         OPC_JMP: begin
            bump_stat(CNT_CTRL, 1);
            sh_ex.alu_out = 8'(sh_dec.imm * 2);
            sh_free[1:0] = 2'b00;
         end
         OPC_BEQZ: begin
            bump_stat(CNT_CTRL, 1);
            sh_ex.alu_out = alu_result(opc, sh_dec.a, sh_dec.imm);
            sh_free[1:0] = 2'b00;
         end
         default: bump_stat(CNT_HALT, 1);
      endcase
   endfunction

   // decode with scoreboard check
   function automatic void stage_decode();
      logic [15:0] w;
      logic [3:0]  opc;
      logic [3:0]  rd;
      logic [3:0]  rs;
      logic [3:0]  rt;
      bit          dep;
      w = sh_fetch;
      dep = 0;
      if (!stage_on(1)) begin
         sh_skip[2] = 1'b1;
         return;
      end
      sh_work++;
      opc = w[15:12];
      rd = w[11:8];
      rs = w[7:4];
      rt = w[3:0];
      sh_dec.opcode = opc;
      sh_dec.rd = rd;
      sh_dec.jump = 1'b0;
      case (opc)
         OPC_ADD, OPC_SUB, OPC_MUL, OPC_AND, OPC_OR, OPC_XOR: begin
            if (sh_busy[rs] != 0 || sh_busy[rt] != 0) dep = 1;
            else begin
               sh_busy[rd] = sh_busy[rd] + 2'd1;
               sh_dec.a = sh_regs[rs];
               sh_dec.b = sh_regs[rt];
            end
         end
         OPC_NOT: begin
            if (sh_busy[rs] != 0) dep = 1;
            else begin
               sh_busy[rd] = sh_busy[rd] + 2'd1;
               sh_dec.a = sh_regs[rs];
               sh_dec.b = '0;
            end
         end
         OPC_SLLI, OPC_SRLI, OPC_LD: begin
            if (sh_busy[rs] != 0) dep = 1;
            else begin
               sh_busy[rd] = sh_busy[rd] + 2'd1;
               sh_dec.a = sh_regs[rs];
               sh_dec.imm = w[7:0];
            end
         end
         OPC_ST: begin
            if (sh_busy[rs] != 0 || sh_busy[rd] != 0) dep = 1;
            else begin
               sh_dec.a = sh_regs[rs];
               sh_dec.imm = w[7:0];
            end
         end
         OPC_INC: begin
            if (sh_busy[rd] != 0) dep = 1;
            else begin
               sh_busy[rd] = sh_busy[rd] + 2'd1;
               sh_dec.a = sh_regs[rd];
               sh_dec.b = '0;
            end
         end
         OPC_LI: begin
            sh_busy[rd] = sh_busy[rd] + 2'd1;
            sh_dec.imm = w[7:0];
         end
         OPC_JMP: begin
            sh_dec.a = '0;
            sh_dec.b = '0;
            sh_dec.jump = 1'b1;
            sh_dec.imm = w[11:4];
         end
         OPC_BEQZ: begin
            if (sh_busy[rd] != 0) dep = 1;
            else begin
               sh_dec.jump = 1'b1;
               sh_dec.a = sh_regs[rd];
               sh_dec.b = '0;
               sh_dec.imm = w[7:0];
            end
         end
         default: sh_skip[0] = 1'b1;
      endcase
      sh_dec.dependency = dep;
      if (dep) begin
         bump_stat(CNT_DSTALL, 1);
         sh_free[0] = 1'b0;
         sh_skip[2] = 1'b1;
      end else if (sh_dec.jump) begin
         bump_stat(CNT_CSTALL, 2);
         sh_free[0] = 1'b0;
         sh_skip[1] = 1'b1;
         sh_skip[2] = 1'b0;
      end else begin
         sh_skip[2] = 1'b0;
      end
   endfunction

   // fetch, second byte wraps at the top of memory
   function automatic void stage_fetch();
      logic [7:0] next_addr;
      if (!stage_on(0)) begin
         if (!sh_dec.dependency) sh_skip[1] = 1'b1;
         return;
      end
      sh_work++;
      next_addr = sh_pc + 8'd1;
      sh_fetch = {sh_imem[sh_pc], sh_imem[next_addr]};
      sh_pc = sh_pc + 8'd2;
      sh_skip[1] = 1'b0;
   endfunction

   function automatic cpu_result_type predict_result(input cpu_item_type it);
      cpu_result_type r;
      r.read_data = '0;
      r.active = 1'b0;
      case (it.op)
         OP_WR_IMEM: sh_imem[it.addr] = it.data;
         OP_WR_DMEM: sh_dmem[it.addr] = it.data;
         OP_WR_REG:  sh_regs[it.addr[3:0]] = it.data;
         OP_RD_DMEM: r.read_data = {24'd0, sh_dmem[it.addr]};
         OP_RD_REG:  r.read_data = {24'd0, sh_regs[it.addr[3:0]]};
         OP_RD_CNT:  r.read_data = (it.addr < NUM_COUNTERS) ? sh_stats[it.addr[3:0]] : '0;
         OP_START:   shadow_start();
         default: begin
            sh_work = 0;
            stage_writeback();
            stage_memory();
            stage_execute();
            stage_decode();
            stage_fetch();
            sh_free = 5'b11111;
            if (sh_work != 0) begin
               bump_stat(CNT_CYCLES, 1);
               r.active = 1'b1;
            end
         end
      endcase
      r.pc = sh_pc;
      return r;
   endfunction

   task automatic queue_item(input op_type op, input logic [7:0] addr, input logic [7:0] data);
      cpu_item_type it;
      it.op = op;
      it.addr = addr;
      it.data = data;
      pending_items.push_back(it);
   endtask

   task automatic load_word(input logic [7:0] addr, input logic [15:0] w);
      queue_item(OP_WR_IMEM, addr, w[15:8]);
      queue_item(OP_WR_IMEM, addr + 8'd1, w[7:0]);
   endtask

   function automatic logic [15:0] random_instr();
      int r;
      logic [3:0] opc;
      logic [3:0] rd;
      r = $urandom_range(0, 99);
      if (r < 3) opc = OPC_HLT;
      else if (r < 8) opc = OPC_JMP;
      else if (r < 14) opc = OPC_BEQZ;
      else opc = 4'($urandom_range(0, 12));
      // small register set keeps hazards frequent
      rd = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
      if ($urandom_range(0, 1) == 0)
         return {opc, rd, 4'($urandom_range(0, 3)), 4'($urandom_range(0, 3))};
      return {opc, rd, 8'($urandom)};
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // stimulus: fill every store first so no entry is read unwritten
   initial begin
      int n;
      shadow_start();
      for (int i = 0; i < 256; i++) begin
         sh_imem[i] = '0;
         sh_dmem[i] = '0;
      end
      for (int i = 0; i < 16; i++) sh_regs[i] = '0;
      error_count = 0;
      accepted_count = 0;
      step_count = 0;
      active_count = 0;
      checked_count = 0;
      stim_done = 0;
      for (int i = 0; i < 256; i++) queue_item(OP_WR_IMEM, 8'(i), 8'($urandom));
      for (int i = 0; i < 256; i++) queue_item(OP_WR_DMEM, 8'(i), 8'($urandom));
      for (int i = 0; i < 16; i++) queue_item(OP_WR_REG, 8'(i), 8'($urandom));

      // directed: extremes, every opcode, large shifts, halt
      queue_item(OP_WR_REG, 8'hff, 8'hff);
      queue_item(OP_WR_REG, 8'h00, 8'h00);
      queue_item(OP_RD_REG, 8'hff, 8'h00);
      queue_item(OP_RD_DMEM, 8'hff, 8'hff);
      queue_item(OP_RD_CNT, 8'hff, 8'h00);
      load_word(8'd0,  {OPC_LI,   4'd1, 8'hff});
      load_word(8'd2,  {OPC_ADD,  4'd2, 4'd15, 4'd1});
      load_word(8'd4,  {OPC_SUB,  4'd3, 4'd0, 4'd1});
      load_word(8'd6,  {OPC_MUL,  4'd4, 4'd1, 4'd1});
      load_word(8'd8,  {OPC_INC,  4'd1, 8'h00});
      load_word(8'd10, {OPC_AND,  4'd5, 4'd1, 4'd2});
      load_word(8'd12, {OPC_OR,   4'd6, 4'd1, 4'd3});
      load_word(8'd14, {OPC_XOR,  4'd7, 4'd2, 4'd4});
      load_word(8'd16, {OPC_NOT,  4'd8, 4'd7, 4'd0});
      load_word(8'd18, {OPC_SLLI, 4'd9, 4'd0, 4'd7});
      load_word(8'd20, {OPC_SRLI, 4'd10, 4'd15, 4'd15});
      load_word(8'd22, {OPC_LD,   4'd11, 4'd15, 4'd0});
      load_word(8'd24, {OPC_ST,   4'd11, 4'd0, 4'd0});
      load_word(8'd26, {OPC_BEQZ, 4'd0, 8'h02});
      load_word(8'd28, {OPC_HLT,  12'h000});
      load_word(8'd30, {OPC_JMP,  8'hff, 4'h0});
      load_word(8'd32, {OPC_HLT,  12'h000});
      queue_item(OP_START, 8'h00, 8'h00);
      for (int i = 0; i < 40; i++) queue_item(OP_STEP, 8'h00, 8'h00);
      for (int i = 0; i < 10; i++) queue_item(OP_RD_CNT, 8'(i), 8'h00);
      queue_item(OP_RD_REG, 8'd10, 8'h00);

      // random programs, mostly stepped, with reads and writes mixed in
      n = 0;
      while (n < 1080) begin
         int len;
         int steps;
         if ($urandom_range(0, 9) == 0) begin
            queue_item(op_type'($urandom_range(0, 7)), 8'($urandom), 8'($urandom));
            n++;
            continue;
         end
         len = $urandom_range(2, 12);
         for (int i = 0; i < len; i++) load_word(8'(2 * i), random_instr());
         queue_item(OP_START, 8'($urandom), 8'($urandom));
         n += 2 * len + 1;
         steps = $urandom_range(10, 50);
         for (int i = 0; i < steps; i++) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 78) queue_item(OP_STEP, 8'($urandom), 8'($urandom));
            else if (r < 84) queue_item(OP_RD_CNT, 8'($urandom_range(0, 11)), 8'($urandom));
            else if (r < 88) queue_item(OP_RD_REG, 8'($urandom), 8'($urandom));
            else if (r < 92) queue_item(OP_RD_DMEM, 8'($urandom), 8'($urandom));
            else if (r < 95) queue_item(OP_WR_REG, 8'($urandom), 8'($urandom));
            else if (r < 98) queue_item(OP_WR_DMEM, 8'($urandom), 8'($urandom));
            else queue_item(OP_WR_IMEM, 8'($urandom), 8'($urandom));
            n++;
         end
         for (int i = 0; i < 10; i++) queue_item(OP_RD_CNT, 8'(i), 8'h00);
         n += 10;
      end
      stim_done = 1;
   end

   // reset and end of run
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = '0;
      req_address = '0;
      req_data = '0;
      rsp_ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && pending_items.size() == 0 && !req_valid
            && expected_results.size() == 0);
      repeat (10) @(posedge clock);
      $display("ran %0d transactions, %0d pipeline steps (%0d active), %0d results checked",
               accepted_count, step_count, active_count, checked_count);
      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // driver and receiver stall, calm stretch without idling
   always @(negedge clock) begin
      bit calm;
      calm = (accepted_count >= 900 && accepted_count < 1200);
      if (!reset) begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 25);
         if (!req_valid || took_item) begin
            if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 25)) begin
               cur_item = pending_items.pop_front();
               req_valid <= 1'b1;
               req_operation <= cur_item.op;
               req_address <= cur_item.addr;
               req_data <= cur_item.data;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
      took_item = 0;
   end

   // monitor: predict on acceptance, check on result transaction
   always @(posedge clock) begin
      cpu_result_type exp_r;
      if (!reset && req_valid && req_ready) begin
         exp_r = predict_result(cur_item);
         expected_results.push_back(exp_r);
         accepted_count++;
         if (cur_item.op == OP_STEP) begin
            step_count++;
            if (exp_r.active) active_count++;
         end
         took_item = 1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result transaction with nothing expected");
         end else begin
            exp_r = expected_results.pop_front();
            checked_count++;
            if (rsp_read_data !== exp_r.read_data)
               report_mismatch($sformatf("read_data got %0h want %0h",
                                         rsp_read_data, exp_r.read_data));
            if (rsp_active !== exp_r.active)
               report_mismatch($sformatf("active got %0b want %0b",
                                         rsp_active, exp_r.active));
            if (rsp_program_counter !== exp_r.pc)
               report_mismatch($sformatf("program_counter got %0h want %0h",
                                         rsp_program_counter, exp_r.pc));
         end
      end
   end

endmodule
